@@ hw/rtl/spr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_pkg
// Shared constants, types and controller commands for the rank engine.
// ----------------------------------------------------------------------------
package spr_pkg;
  localparam int MaxNodes = 64;
  localparam int MaxEdges = 256;
  localparam int NodeW = 6;
  localparam int EdgeW = 8;
  localparam int CntW = 9;
  localparam int DegW = 9;
  localparam int RankW = 32;
  localparam int IterW = 16;
  localparam logic [RankW-1:0] Q31One = 32'h8000_0000;
  localparam logic OpAddEdge = 1'b0;
  localparam logic OpRun = 1'b1;

  typedef struct packed {
    logic add_edge;
    logic add_deg;
    logic count_start;
    logic count_step;
    logic div_start;
    logic div_run;
    logic init_step;
    logic clear_step;
    logic edge_rd;
    logic src_rd;
    logic share_start;
    logic acc_step;
    logic commit_rd;
    logic commit_step;
    logic emit_rd;
    logic emit_step;
    logic scan_reset;
  } spr_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic edge_done;
    logic div_busy;
    logic changed;
    logic node_cnt_zero;
    logic cur_present;
    logic share_zero;
  } spr_status_t;
endpackage

@@ hw/rtl/spr_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_in_if / spr_out_if
// Valid/ready channels for command beats and rank beats.
// ----------------------------------------------------------------------------
interface spr_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic [5:0] from_node;
  logic [5:0] to_node;
  logic [15:0] power_iterations;
  modport source (output valid, opcode, from_node, to_node, power_iterations, input ready);
  modport sink (input valid, opcode, from_node, to_node, power_iterations, output ready);
endinterface

interface spr_out_if;
  logic valid;
  logic ready;
  logic [5:0] node_index;
  logic [31:0] rank_value;
  logic last_result;
  modport source (output valid, node_index, rank_value, last_result, input ready);
  modport sink (input valid, node_index, rank_value, last_result, output ready);
endinterface

@@ hw/rtl/spr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_div
// Restoring divider, one quotient bit per cycle, 32-bit dividend.
// ----------------------------------------------------------------------------
module spr_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [8:0]  divisor,
  output logic        busy,
  output logic [31:0] quotient
);
  logic [5:0]  bits;
  logic [31:0] rem;
  logic [8:0]  dvs;
  logic [32:0] trial;

  assign busy = (bits != 6'd0);
  assign trial = {rem, quotient[31]} - {24'd0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      bits <= 6'd0;
    end else if (start) begin
      bits <= 6'd32;
    end else if (busy) begin
      bits <= bits - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 32'd0;
      quotient <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], quotient[31]};
        quotient <= {quotient[30:0], 1'b0};
      end
    end
  end
endmodule

@@ hw/rtl/spr_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_datapath
// Graph store, rank memories, scan counters and shared divider.
// ----------------------------------------------------------------------------
module spr_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  spr_pkg::spr_cmd_t     cmd,
  input  logic [5:0]            from_node,
  input  logic [5:0]            to_node,
  output spr_pkg::spr_status_t  status,
  output logic [5:0]            node_index,
  output logic [31:0]           rank_value,
  output logic                  last_hint
);
  import spr_pkg::*;

  logic [MaxNodes-1:0] present;
  logic [MaxNodes-1:0] deg_valid;
  logic [DegW-1:0]     degree [MaxNodes];
  logic [NodeW-1:0]    esrc [MaxEdges];
  logic [NodeW-1:0]    edst [MaxEdges];
  logic [CntW-1:0]     ecount;
  logic [RankW-1:0]    cur [MaxNodes];
  logic [RankW-1:0]    nxt [MaxNodes];
  logic [NodeW:0]      scan;
  logic [NodeW-1:0]    scan_lo;
  logic [CntW-1:0]     eidx;
  logic [NodeW:0]      ncount;
  logic [RankW-1:0]    init_rank;
  logic                changed;
  logic                add_ok_now;
  logic                add_ok;
  logic [NodeW-1:0]    add_from;
  logic [NodeW-1:0]    s_q;
  logic [NodeW-1:0]    t_q;
  logic [DegW-1:0]     deg_q;
  logic                degv_q;
  logic [DegW-1:0]     deg_eff;
  logic [NodeW-1:0]    deg_addr;
  logic [RankW-1:0]    cur_q;
  logic [RankW-1:0]    nxt_q;
  logic [RankW-1:0]    cur_wdata;
  logic [RankW-1:0]    commit_val;
  logic [NodeW-1:0]    cur_addr;
  logic [NodeW-1:0]    nxt_raddr;
  logic [NodeW-1:0]    nxt_waddr;
  logic [RankW-1:0]    nxt_wdata;
  logic                div_start;
  logic                div_busy;
  logic [RankW-1:0]    quot;
  logic [RankW-1:0]    dividend;
  logic [DegW-1:0]     divisor;
  logic [MaxNodes-1:0] above;

  assign scan_lo = scan[NodeW-1:0];
  assign add_ok_now = cmd.add_edge && (ecount != CntW'(MaxEdges));
  assign deg_addr = cmd.add_edge ? from_node : s_q;
  assign deg_eff = degv_q ? deg_q : '0;
  assign commit_val = present[scan_lo] ? nxt_q : '0;
  assign cur_wdata = cmd.init_step ? (present[scan_lo] ? init_rank : '0) : commit_val;
  assign cur_addr = cmd.src_rd ? s_q : scan_lo;
  assign nxt_raddr = cmd.src_rd ? t_q : scan_lo;
  assign nxt_waddr = cmd.acc_step ? t_q : scan_lo;
  assign nxt_wdata = cmd.acc_step ? nxt_q + quot : '0;
  assign div_start = cmd.div_start || cmd.share_start;
  assign dividend = cmd.div_start ? Q31One : cur_q;
  assign divisor = cmd.div_start ? {2'd0, ncount} : deg_eff;

  spr_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(dividend),
    .divisor(divisor), .busy(div_busy), .quotient(quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      deg_valid <= '0;
      ecount <= '0;
      add_ok <= 1'b0;
    end else begin
      add_ok <= add_ok_now;
      if (add_ok_now) begin
        ecount <= ecount + 1'b1;
        present[from_node] <= 1'b1;
        present[to_node] <= 1'b1;
      end
      if (cmd.add_edge) add_from <= from_node;
      if (cmd.add_deg && add_ok) deg_valid[add_from] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (add_ok_now) begin
      esrc[ecount[EdgeW-1:0]] <= from_node;
      edst[ecount[EdgeW-1:0]] <= to_node;
    end
    if (cmd.edge_rd) begin
      s_q <= esrc[eidx[EdgeW-1:0]];
      t_q <= edst[eidx[EdgeW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add_deg && add_ok) degree[add_from] <= deg_eff + 1'b1;
    if (cmd.add_edge || cmd.src_rd) begin
      deg_q <= degree[deg_addr];
      degv_q <= deg_valid[deg_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init_step || cmd.commit_step) cur[scan_lo] <= cur_wdata;
    if (cmd.src_rd || cmd.commit_rd || cmd.emit_rd) cur_q <= cur[cur_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step || cmd.acc_step) nxt[nxt_waddr] <= nxt_wdata;
    if (cmd.src_rd || cmd.commit_rd) nxt_q <= nxt[nxt_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.div_run && !div_busy) init_rank <= quot;
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_reset || cmd.count_start) begin
      scan <= '0;
      eidx <= '0;
      changed <= 1'b0;
      if (cmd.count_start) ncount <= '0;
    end else begin
      if (cmd.count_step) ncount <= ncount + {{NodeW{1'b0}}, present[scan_lo]};
      if (cmd.count_step || cmd.init_step || cmd.clear_step || cmd.commit_step ||
          cmd.emit_step) scan <= scan + 1'b1;
      if (cmd.edge_rd) eidx <= eidx + 1'b1;
      if (cmd.commit_step && commit_val != cur_q) changed <= 1'b1;
    end
  end

  always_comb begin
    for (int i = 0; i < MaxNodes; i++) above[i] = (i > int'(scan_lo));
  end

  assign node_index = scan_lo;
  assign rank_value = cur_q;
  assign last_hint = ((present & above) == '0);
  assign status.scan_done = scan[NodeW];
  assign status.edge_done = (eidx == ecount);
  assign status.div_busy = div_busy;
  assign status.changed = changed;
  assign status.node_cnt_zero = (ncount == '0);
  assign status.cur_present = present[scan_lo];
  assign status.share_zero = (deg_eff == '0);
endmodule

@@ hw/rtl/spr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spr_ctrl
// Sequencer for edge loads, rank init, power iterations and emission.
// ----------------------------------------------------------------------------
module spr_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_opcode,
  input  logic [15:0]          in_iters,
  output logic                 in_ready,
  input  spr_pkg::spr_status_t status,
  output spr_pkg::spr_cmd_t    cmd,
  input  logic                 last_hint,
  output logic                 out_valid,
  output logic                 out_last,
  input  logic                 out_ready
);
  import spr_pkg::*;

  localparam logic [4:0] SIdle = 5'd0, SAddDeg = 5'd1, SCount = 5'd2, SDivGo = 5'd3,
    SDiv = 5'd4, SInit = 5'd5, SIter = 5'd6, SClear = 5'd7, SEdge = 5'd8,
    SEdgeSrc = 5'd9, SShareGo = 5'd10, SShareWait = 5'd11, SCommitRd = 5'd12,
    SCommit = 5'd13, SCheck = 5'd14, SEmitRd = 5'd15, SEmit = 5'd16;

  logic [4:0]       state;
  logic [4:0]       state_next;
  logic [IterW-1:0] iters;
  logic [IterW-1:0] done_it;

  assign in_ready = (state == SIdle);
  assign out_valid = (state == SEmit);
  assign out_last = last_hint;

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      SIdle: if (in_valid) begin
        if (in_opcode == OpAddEdge) begin
          cmd.add_edge = 1'b1;
          state_next = SAddDeg;
        end else begin
          cmd.count_start = 1'b1;
          state_next = SCount;
        end
      end
      SAddDeg: begin
        cmd.add_deg = 1'b1;
        state_next = SIdle;
      end
      SCount: begin
        if (status.scan_done) begin
          state_next = status.node_cnt_zero ? SIdle : SDivGo;
        end else cmd.count_step = 1'b1;
      end
      SDivGo: begin
        cmd.div_start = 1'b1;
        state_next = SDiv;
      end
      SDiv: begin
        cmd.div_run = 1'b1;
        if (!status.div_busy) begin
          cmd.scan_reset = 1'b1;
          state_next = SInit;
        end
      end
      SInit: begin
        if (status.scan_done) state_next = SIter;
        else cmd.init_step = 1'b1;
      end
      SIter: begin
        cmd.scan_reset = 1'b1;
        state_next = (done_it >= iters) ? SEmitRd : SClear;
      end
      SClear: begin
        if (status.scan_done) begin
          cmd.scan_reset = 1'b1;
          state_next = SEdge;
        end else cmd.clear_step = 1'b1;
      end
      SEdge: begin
        if (status.edge_done) state_next = SCommitRd;
        else begin
          cmd.edge_rd = 1'b1;
          state_next = SEdgeSrc;
        end
      end
      SEdgeSrc: begin
        cmd.src_rd = 1'b1;
        state_next = SShareGo;
      end
      SShareGo: begin
        if (status.share_zero) state_next = SEdge;
        else begin
          cmd.share_start = 1'b1;
          state_next = SShareWait;
        end
      end
      SShareWait: begin
        if (!status.div_busy) begin
          cmd.acc_step = 1'b1;
          state_next = SEdge;
        end
      end
      SCommitRd: begin
        if (status.scan_done) state_next = SCheck;
        else begin
          cmd.commit_rd = 1'b1;
          state_next = SCommit;
        end
      end
      SCommit: begin
        cmd.commit_step = 1'b1;
        state_next = SCommitRd;
      end
      SCheck: begin
        if (status.changed) state_next = SIter;
        else begin
          cmd.scan_reset = 1'b1;
          state_next = SEmitRd;
        end
      end
      SEmitRd: begin
        if (status.scan_done) state_next = SIdle;
        else if (!status.cur_present) cmd.emit_step = 1'b1;
        else begin
          cmd.emit_rd = 1'b1;
          state_next = SEmit;
        end
      end
      SEmit: begin
        if (out_ready) begin
          cmd.emit_step = 1'b1;
          state_next = SEmitRd;
        end
      end
      default: state_next = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
      iters <= '0;
      done_it <= '0;
    end else begin
      state <= state_next;
      if (state == SIdle && in_valid && in_opcode == OpRun) begin
        iters <= in_iters;
        done_it <= 16'd1;
      end
      if (state == SIter && done_it < iters) done_it <= done_it + 1'b1;
    end
  end
endmodule

@@ hw/rtl/simplified_pagerank_engine_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simplified_pagerank_engine_top
// Power-iteration rank engine over a stored directed graph.
// ----------------------------------------------------------------------------
// An add-edge beat stores the edge, then updates the degree. A run beat
// counts present nodes, divides for the initial rank, initializes ranks,
// then per iteration clears, walks each edge through the shared bit-serial
// divider and commits, stopping early once ranks settle. Rank beats follow,
// one per present node, each held until the sink is ready; absent nodes
// are skipped, and a run with no present node returns to idle with none.
// One item is worked at a time.
module simplified_pagerank_engine_top (
  input logic clk,
  input logic rst,
  spr_in_if.sink    in_ch,
  spr_out_if.source out_ch
);
  import spr_pkg::*;

  spr_cmd_t    cmd;
  spr_status_t status;
  logic        last_hint;

  spr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_opcode(in_ch.opcode),
    .in_iters(in_ch.power_iterations), .in_ready(in_ch.ready), .status(status),
    .cmd(cmd), .last_hint(last_hint), .out_valid(out_ch.valid),
    .out_last(out_ch.last_result), .out_ready(out_ch.ready)
  );

  spr_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .from_node(in_ch.from_node),
    .to_node(in_ch.to_node), .status(status), .node_index(out_ch.node_index),
    .rank_value(out_ch.rank_value), .last_hint(last_hint)
  );

`ifndef SYNTHESIS
  a_no_out_while_in: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid) else $error("output during input");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.node_index))
    else $error("output beat dropped");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.init_step, cmd.clear_step, cmd.commit_step, cmd.emit_step}))
    else $error("scan command conflict");
`endif
endmodule
